// ----- rtl/ssp_pkg.sv -----
package ssp_pkg;

  // display memory geometry
  localparam int unsigned BitmapBytes = 6144;
  localparam int unsigned AttrBytes   = 768;
  localparam int unsigned BitmapAw    = $clog2(BitmapBytes);
  localparam int unsigned AttrAw      = $clog2(AttrBytes);

  // request codes
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdPixel = 1'b1;

  // cpu address decode: bitmap 0x4000..0x57ff, attributes 0x5800..0x5aff
  localparam logic [2:0] ScrPage    = 3'b010;
  localparam logic [1:0] AttrBank   = 2'b11;
  localparam logic [2:0] AttrPages  = 3'd3;

  // paper window inside the cropped frame
  localparam logic [8:0] PaperColLo = 9'd20;
  localparam logic [8:0] PaperColHi = 9'd276;
  localparam logic [7:0] PaperRowLo = 8'd8;
  localparam logic [7:0] PaperRowHi = 8'd200;
  localparam logic [8:0] CropRowOff = 9'd8;

  // pixel request carried next to the memory read
  typedef struct packed {
    logic       in_paper;
    logic [2:0] bit_sel;
    logic       flash;
  } ssp_pix_t;

endpackage

// ----- rtl/ssp_ram.sv -----
module ssp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ssp_front.sv -----
module ssp_front
  import ssp_pkg::*;
(
  input  logic                cmd_i,
  input  logic [15:0]         address_i,
  input  logic [8:0]          column_i,
  input  logic [7:0]          row_i,
  input  logic [7:0]          beam_line_i,
  input  logic                flash_phase_i,
  output logic                bm_wsel_o,
  output logic                at_wsel_o,
  output logic [BitmapAw-1:0] bm_waddr_o,
  output logic [AttrAw-1:0]   at_waddr_o,
  output logic [BitmapAw-1:0] bm_raddr_o,
  output logic [AttrAw-1:0]   at_raddr_o,
  output ssp_pix_t            pix_o
);

  logic [7:0] lx;
  logic [7:0] ly;
  logic [8:0] y_full;
  logic       in_win;

  // write decode into bitmap or attribute area
  always_comb begin
    bm_wsel_o  = (cmd_i == CmdWrite) && (address_i[15:13] == ScrPage)
                 && (address_i[12:11] != AttrBank);
    at_wsel_o  = (cmd_i == CmdWrite) && (address_i[15:13] == ScrPage)
                 && (address_i[12:11] == AttrBank) && (address_i[10:8] < AttrPages);
    bm_waddr_o = address_i[BitmapAw-1:0];
    at_waddr_o = address_i[AttrAw-1:0];
  end

  // paper window test and local coordinates
  always_comb begin
    y_full = {1'b0, row_i} + CropRowOff;
    in_win = (column_i >= PaperColLo) && (column_i < PaperColHi)
             && (row_i >= PaperRowLo) && (row_i < PaperRowHi)
             && (y_full < {1'b0, beam_line_i});
    lx     = 8'(column_i - PaperColLo);
    ly     = row_i - PaperRowLo;
  end

  // interleaved bitmap address and linear attribute address
  always_comb begin
    bm_raddr_o   = {ly[7:6], ly[2:0], ly[5:3], lx[7:3]};
    at_raddr_o   = {ly[7:3], lx[7:3]};
    pix_o.in_paper = in_win;
    pix_o.bit_sel  = ~lx[2:0];
    pix_o.flash    = flash_phase_i;
  end

endmodule

// ----- rtl/ssp_shade.sv -----
module ssp_shade
  import ssp_pkg::*;
(
  input  ssp_pix_t   pix_i,
  input  logic [7:0] bits_i,
  input  logic [7:0] attr_i,
  input  logic [2:0] border_i,
  output logic [3:0] pixel_index_o,
  output logic       in_paper_o
);

  logic ink_on;
  logic swap;

  // ink or paper selection with flash swap
  always_comb begin
    ink_on = bits_i[pix_i.bit_sel];
    swap   = attr_i[7] & pix_i.flash;
    if (!pix_i.in_paper) begin
      pixel_index_o = {1'b0, border_i};
    end else if (ink_on != swap) begin
      pixel_index_o = {attr_i[6], attr_i[2:0]};
    end else begin
      pixel_index_o = {attr_i[6], attr_i[5:3]};
    end
    in_paper_o = pix_i.in_paper;
  end

endmodule

// ----- rtl/spectrum_screen_pixel_generator_unit.sv -----
// a pixel request is registered beside the memory read, then in the result register
// throughput: one request per cycle unless stalled, set by single synchronous memory reads
// write requests update the display memory at acceptance if they decode into it, and give no result
// reset clears the pipeline valid flags and the border color to 0
// display memory contents are undefined until written; no clearing pass
module spectrum_screen_pixel_generator_unit
  import ssp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  data_i,
  input  logic [8:0]  column_i,
  input  logic [7:0]  row_i,
  input  logic [7:0]  beam_line_i,
  input  logic        flash_phase_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  pixel_index_o,
  output logic        in_paper_o
);

  logic [2:0]          border_color_q;
  logic                accept;
  logic                advance;
  logic                pix_req;
  logic                bm_wsel;
  logic                at_wsel;
  logic [BitmapAw-1:0] bm_waddr;
  logic [AttrAw-1:0]   at_waddr;
  logic [BitmapAw-1:0] bm_raddr;
  logic [AttrAw-1:0]   at_raddr;
  logic [7:0]          bm_rdata;
  logic [7:0]          at_rdata;
  ssp_pix_t            pix_d;
  ssp_pix_t            pix_q;
  logic                s1_valid_q;
  logic                out_valid_q;
  logic [3:0]          pixel_d;
  logic [3:0]          pixel_q;
  logic                paper_d;
  logic                paper_q;

  // handshake
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;
  assign pix_req    = accept && (cmd_i == CmdPixel);

  // address generation and write decode
  ssp_front u_front (
    .cmd_i        (cmd_i),
    .address_i    (address_i),
    .column_i     (column_i),
    .row_i        (row_i),
    .beam_line_i  (beam_line_i),
    .flash_phase_i(flash_phase_i),
    .bm_wsel_o    (bm_wsel),
    .at_wsel_o    (at_wsel),
    .bm_waddr_o   (bm_waddr),
    .at_waddr_o   (at_waddr),
    .bm_raddr_o   (bm_raddr),
    .at_raddr_o   (at_raddr),
    .pix_o        (pix_d)
  );

  // bitmap memory
  ssp_ram #(
    .Width(8),
    .Depth(BitmapBytes)
  ) u_bitmap_ram (
    .clk_i  (clk_i),
    .we_i   (accept && bm_wsel),
    .waddr_i(bm_waddr),
    .wdata_i(data_i),
    .re_i   (pix_req),
    .raddr_i(bm_raddr),
    .rdata_o(bm_rdata)
  );

  // attribute memory
  ssp_ram #(
    .Width(8),
    .Depth(AttrBytes)
  ) u_attr_ram (
    .clk_i  (clk_i),
    .we_i   (accept && at_wsel),
    .waddr_i(at_waddr),
    .wdata_i(data_i),
    .re_i   (pix_req),
    .raddr_i(at_raddr),
    .rdata_o(at_rdata)
  );

  // color selection
  ssp_shade u_shade (
    .pix_i        (pix_q),
    .bits_i       (bm_rdata),
    .attr_i       (at_rdata),
    .border_i     (border_color_q),
    .pixel_index_o(pixel_d),
    .in_paper_o   (paper_d)
  );

  // border color register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      border_color_q <= 3'd0;
    end else if (cfg_we_i) begin
      border_color_q <= cfg_wdata_i;
    end
  end

  // request stage alongside the memory read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= pix_req;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_req) begin
      pix_q <= pix_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      pixel_q <= pixel_d;
      paper_q <= paper_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_index_o = pixel_q;
  assign in_paper_o    = paper_q;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import ssp_pkg::*;

  localparam int unsigned ScreenBase  = 16'h4000;
  localparam int unsigned ScreenBytes = 6912;
  localparam int unsigned AttrOffset  = 6144;
  localparam int unsigned CropW       = 296;
  localparam int unsigned CropH       = 208;
  localparam int unsigned CropDx      = 12;
  localparam int unsigned CropDy      = 8;
  localparam int unsigned PaperX      = 32;
  localparam int unsigned PaperY      = 16;
  localparam int unsigned PaperW      = 256;
  localparam int unsigned PaperH      = 192;
  localparam int unsigned PhaseItems  = 80;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned CycleLimit  = 300000;

  typedef struct packed {
    logic       cmd;
    logic [15:0] address;
    logic [7:0] data;
    logic [8:0] column;
    logic [7:0] row;
    logic [7:0] beam;
    logic       flash;
    logic       typed;
    logic [3:0] exp_idx;
    logic       exp_paper;
  } req_t;

  typedef struct packed {
    logic [3:0] idx;
    logic       paper;
  } pix_res_t;

  // directed requests; border is still at its reset value of 0 here
  localparam req_t DirTab [26] = '{
    '{CmdWrite, 16'h0000, 8'hFF, 9'd0,   8'd0,   8'd0,   1'b0, 1'b0, 4'd0,  1'b0},
    '{CmdWrite, 16'h3FFF, 8'hFF, 9'd0,   8'd0,   8'd0,   1'b0, 1'b0, 4'd0,  1'b0},
    '{CmdWrite, 16'h5B00, 8'hA5, 9'd0,   8'd0,   8'd0,   1'b0, 1'b0, 4'd0,  1'b0},
    '{CmdWrite, 16'hFFFF, 8'h00, 9'd0,   8'd0,   8'd0,   1'b0, 1'b0, 4'd0,  1'b0},
    '{CmdPixel, 16'h0000, 8'h00, 9'd0,   8'd0,   8'd224, 1'b0, 1'b1, 4'd0,  1'b0},
    '{CmdPixel, 16'h0000, 8'h00, 9'd295, 8'd207, 8'd255, 1'b1, 1'b1, 4'd0,  1'b0},
    '{CmdPixel, 16'hFFFF, 8'hFF, 9'd511, 8'd255, 8'd0,   1'b0, 1'b1, 4'd0,  1'b0},
    '{CmdWrite, 16'h4000, 8'h80, 9'd0,   8'd0,   8'd0,   1'b0, 1'b0, 4'd0,  1'b0},
    '{CmdWrite, 16'h5800, 8'h47, 9'd0,   8'd0,   8'd0,   1'b0, 1'b0, 4'd0,  1'b0},
    '{CmdPixel, 16'h0000, 8'h00, 9'd20,  8'd8,   8'd224, 1'b0, 1'b1, 4'd15, 1'b1},
    '{CmdPixel, 16'h0000, 8'h00, 9'd21,  8'd8,   8'd224, 1'b0, 1'b1, 4'd8,  1'b1},
    '{CmdPixel, 16'h0000, 8'h00, 9'd20,  8'd8,   8'd16,  1'b0, 1'b1, 4'd0,  1'b0},
    '{CmdPixel, 16'h0000, 8'h00, 9'd20,  8'd8,   8'd17,  1'b0, 1'b1, 4'd15, 1'b1},
    '{CmdWrite, 16'h5800, 8'hC7, 9'd0,   8'd0,   8'd0,   1'b0, 1'b0, 4'd0,  1'b0},
    '{CmdPixel, 16'h0000, 8'h00, 9'd20,  8'd8,   8'd224, 1'b1, 1'b1, 4'd8,  1'b1},
    '{CmdPixel, 16'h0000, 8'h00, 9'd21,  8'd8,   8'd224, 1'b1, 1'b1, 4'd15, 1'b1},
    '{CmdWrite, 16'h57FF, 8'h01, 9'd0,   8'd0,   8'd0,   1'b0, 1'b0, 4'd0,  1'b0},
    '{CmdWrite, 16'h5AFF, 8'h3A, 9'd0,   8'd0,   8'd0,   1'b0, 1'b0, 4'd0,  1'b0},
    '{CmdPixel, 16'h0000, 8'h00, 9'd275, 8'd199, 8'd224, 1'b1, 1'b1, 4'd2,  1'b1},
    '{CmdPixel, 16'h0000, 8'h00, 9'd274, 8'd199, 8'd224, 1'b0, 1'b1, 4'd7,  1'b1},
    '{CmdPixel, 16'h0000, 8'h00, 9'd276, 8'd199, 8'd224, 1'b0, 1'b1, 4'd0,  1'b0},
    '{CmdPixel, 16'h0000, 8'h00, 9'd19,  8'd8,   8'd224, 1'b0, 1'b1, 4'd0,  1'b0},
    '{CmdPixel, 16'h0000, 8'h00, 9'd20,  8'd7,   8'd224, 1'b0, 1'b1, 4'd0,  1'b0},
    '{CmdPixel, 16'h0000, 8'h00, 9'd20,  8'd200, 8'd224, 1'b0, 1'b1, 4'd0,  1'b0},
    '{CmdWrite, 16'h5AFF, 8'h9D, 9'd0,   8'd0,   8'd0,   1'b0, 1'b0, 4'd0,  1'b0},
    '{CmdPixel, 16'h0000, 8'h00, 9'd275, 8'd199, 8'd224, 1'b1, 1'b0, 4'd0,  1'b0}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_wdata = 3'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       cmd = 1'b0;
  logic [15:0] address = 16'd0;
  logic [7:0] data = 8'd0;
  logic [8:0] column = 9'd0;
  logic [7:0] row = 8'd0;
  logic [7:0] beam = 8'd0;
  logic       flash = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [3:0] pixel_index;
  logic       in_paper;

  // shadow of the display memory and border register
  logic [7:0] disp_mem [ScreenBytes];
  bit         written [ScreenBytes];
  logic [2:0] border_q = 3'd0;

  pix_res_t   pixel_q [$];
  pix_res_t   head_res;
  int unsigned err_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned stall_left = 0;
  int unsigned cycle_cnt = 0;
  bit         hold_done = 1'b0;
  logic       calm = 1'b0;

  spectrum_screen_pixel_generator_unit u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .cmd_i         (cmd),
    .address_i     (address),
    .data_i        (data),
    .column_i      (column),
    .row_i         (row),
    .beam_line_i   (beam),
    .flash_phase_i (flash),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .pixel_index_o (pixel_index),
    .in_paper_o    (in_paper)
  );

  always #5 clk = ~clk;

  // locate the bitmap and attribute bytes behind a pixel, if it shows paper
  function automatic bit paper_hit(input logic [8:0] col, input logic [7:0] rw,
                                   input logic [7:0] bl, output int unsigned bmp_off,
                                   output int unsigned attr_off, output int unsigned bit_pos);
    int unsigned x;
    int unsigned y;
    int unsigned lx;
    int unsigned ly;
    x = col + CropDx;
    y = rw + CropDy;
    bmp_off = 0;
    attr_off = 0;
    bit_pos = 0;
    if (!(col < CropW && rw < CropH && x >= PaperX && x < PaperX + PaperW &&
          y >= PaperY && y < PaperY + PaperH && y < bl)) begin
      return 1'b0;
    end
    lx = x - PaperX;
    ly = y - PaperY;
    bmp_off = ((ly & 'hC0) << 5) | ((ly & 'h07) << 8) | ((ly & 'h38) << 2) | (lx >> 3);
    attr_off = AttrOffset + ((ly >> 3) << 5) + (lx >> 3);
    bit_pos = 7 - (lx & 7);
    return 1'b1;
  endfunction

  // palette index of one pixel from the shadow memory
  function automatic pix_res_t pixel_color(input req_t r);
    pix_res_t res;
    int unsigned b_off;
    int unsigned a_off;
    int unsigned bit_pos;
    logic [7:0] attr;
    logic [7:0] bits;
    logic on;
    logic swap;
    res.idx = {1'b0, border_q};
    res.paper = 1'b0;
    if (paper_hit(r.column, r.row, r.beam, b_off, a_off, bit_pos)) begin
      attr = disp_mem[a_off];
      bits = disp_mem[b_off];
      on = bits[bit_pos];
      swap = attr[7] & r.flash;
      res.idx = {attr[6], (on != swap) ? attr[2:0] : attr[5:3]};
      res.paper = 1'b1;
    end
    return res;
  endfunction

  function automatic bit screen_addr(input logic [15:0] a);
    return a >= ScreenBase && a < ScreenBase + ScreenBytes;
  endfunction

  // offer one request and update the shadow state once it is taken
  task automatic send_item(input req_t r);
    pix_res_t res;
    if (!calm) begin
      while ($urandom_range(99) < 34) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    cmd      <= r.cmd;
    address  <= r.address;
    data     <= r.data;
    column   <= r.column;
    row      <= r.row;
    beam     <= r.beam;
    flash    <= r.flash;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (r.cmd == CmdWrite) begin
      if (screen_addr(r.address)) begin
        disp_mem[r.address - ScreenBase] = r.data;
        written[r.address - ScreenBase] = 1'b1;
      end
    end else begin
      if (r.typed) begin
        res.idx = r.exp_idx;
        res.paper = r.exp_paper;
      end else begin
        res = pixel_color(r);
      end
      pixel_q = {pixel_q, res};
    end
  endtask

  // wait for the pipeline to empty, then change the border color
  task automatic set_border(input logic [2:0] v);
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    border_q = v;
  endtask

  // stimulus
  initial begin
    req_t r;
    req_t w;
    int unsigned pick;
    int unsigned sent;
    int unsigned offs [2];
    int unsigned bit_pos;
    logic [2:0] borders [5];
    borders[0] = 3'd7;
    borders[1] = 3'd0;
    borders[2] = 3'($urandom);
    borders[3] = 3'd2;
    borders[4] = 3'($urandom);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < $size(DirTab); i++) begin
      send_item(DirTab[i]);
    end

    for (int ph = 0; ph < 5; ph++) begin
      set_border(borders[ph]);
      sent = 0;
      if (ph == 2) calm <= 1'b1;
      while (sent < PhaseItems) begin
        if (ph == 2 && sent >= 60) calm <= 1'b0;
        pick = $urandom_range(99);
        r = '0;
        r.address = 16'($urandom);
        r.data    = 8'($urandom);
        r.column  = 9'($urandom);
        r.row     = 8'($urandom);
        r.beam    = 8'($urandom);
        r.flash   = 1'($urandom);
        if (pick < 40) begin
          r.cmd = CmdWrite;
          r.address = 16'(ScreenBase + $urandom_range(ScreenBytes - 1));
        end else if (pick < 46) begin
          r.cmd = CmdWrite;
          r.address = $urandom_range(1) ? 16'($urandom_range(16'h3FFF))
                                        : 16'($urandom_range(16'hFFFF, 16'h5B00));
        end else if (pick < 90) begin
          r.cmd = CmdPixel;
          r.column = 9'($urandom_range(275, 20));
          r.row = 8'($urandom_range(199, 8));
          if ($urandom_range(3) != 0) r.beam = 8'd224;
        end else begin
          r.cmd = CmdPixel;
        end
        // a paper pixel needs both of its bytes written first
        if (r.cmd == CmdPixel &&
            paper_hit(r.column, r.row, r.beam, offs[0], offs[1], bit_pos)) begin
          foreach (offs[k]) begin
            if (!written[offs[k]]) begin
              w = '0;
              w.cmd = CmdWrite;
              w.address = 16'(ScreenBase + offs[k]);
              w.data = 8'($urandom);
              w.column = 9'($urandom);
              w.row = 8'($urandom);
              w.beam = 8'($urandom);
              w.flash = 1'($urandom);
              send_item(w);
              sent++;
            end
          end
        end
        send_item(r);
        if (r.cmd == CmdPixel || screen_addr(r.address)) sent++;
      end
    end

    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // result side: check each taken result and pace the ready
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      results_seen++;
      if (pixel_q.size() == 0) begin
        $display("%0t: result with no request pending, index %0d paper %0b",
                 $time, pixel_index, in_paper);
        err_cnt++;
      end else begin
        head_res = pixel_q.pop_front();
        if (head_res.idx !== pixel_index) begin
          $display("%0t: pixel_index expected %0d actual %0d",
                   $time, head_res.idx, pixel_index);
          err_cnt++;
        end
        if (head_res.paper !== in_paper) begin
          $display("%0t: in_paper expected %0b actual %0b",
                   $time, head_res.paper, in_paper);
          err_cnt++;
        end
      end
    end
    // one long hold-off so the pipeline backs up into the input
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= 120) begin
      hold_done = 1'b1;
      stall_left = HoldCycles;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 34);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

endmodule

// ----- spectrum_screen_pixel_generator_unit.f -----
rtl/ssp_pkg.sv
rtl/ssp_ram.sv
rtl/ssp_front.sv
rtl/ssp_shade.sv
rtl/spectrum_screen_pixel_generator_unit.sv
bench/tb.sv
